// ----- hdl/hpe_pkg.sv -----
// Shared types and constants for the homogeneous polynomial norm pipeline.
package hpe_pkg;

   localparam int POINT_W     = 32;
   localparam int COEF_W      = 40;
   localparam int DEG_W       = 3;
   localparam int LIMB_W      = 32;
   localparam int NORM_W      = 64;
   localparam int GUARD_W     = 3;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 40;

   // Register indexes of the configuration port
   localparam logic [CSR_INDEX_W-1:0] CSR_POLY_DEGREE = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_COEF_0      = 3'd1;

   localparam logic [DEG_W-1:0]  DEG_RESET = 3'd1;
   localparam logic [NORM_W-1:0] NORM_MAX  = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [NORM_W-1:0] NORM_MIN  = 64'h8000_0000_0000_0000;

   typedef struct packed {
      logic signed [POINT_W-1:0] point_a;
      logic        [POINT_W-1:0] point_b;
   } hpe_req_type;

   typedef struct packed {
      logic signed [NORM_W-1:0] norm_value;
      logic                     saturated;
   } hpe_rsp_type;

   // Per-point context that travels with the data down the pipeline
   typedef struct packed {
      logic        [DEG_W-1:0]   degree;
      logic signed [POINT_W-1:0] point_a;
      logic        [POINT_W-1:0] point_b;
   } hpe_lane_type;

endpackage

// ----- hdl/hpe_horner_step.sv -----
// One homogeneous Horner step: r' = r * a + c_i * b^k, b^(k+1) = b^k * b, three stages.
module hpe_horner_step #(
   parameter int MAX_DEGREE = 6,
   parameter int STEP       = 0,
   localparam int ACC_W = hpe_pkg::COEF_W + hpe_pkg::LIMB_W * MAX_DEGREE + hpe_pkg::GUARD_W,
   localparam int POW_W = hpe_pkg::LIMB_W * MAX_DEGREE
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              up_valid,
   output logic                              up_ready,
   input  hpe_pkg::hpe_lane_type             up_lane,
   input  logic signed [ACC_W-1:0]           r_in,
   input  logic        [POW_W-1:0]           bp_in,
   input  logic signed [hpe_pkg::COEF_W-1:0] coef,
   output logic                              down_valid,
   input  logic                              down_ready,
   output hpe_pkg::hpe_lane_type             down_lane,
   output logic signed [ACC_W-1:0]           r_out,
   output logic        [POW_W-1:0]           bp_out
);
   import hpe_pkg::*;

   localparam int COEF_IDX = MAX_DEGREE - 1 - STEP;
   localparam int NLR      = STEP + 2;
   localparam int NLB      = STEP + 1;
   localparam int RO_W     = COEF_W + LIMB_W * (STEP + 1) + GUARD_W;
   localparam int PA_W     = 2 * LIMB_W + 1;
   localparam int PC_W     = LIMB_W + 1 + COEF_W;
   localparam bit HAS_NEXT = (STEP < MAX_DEGREE - 1);

   logic v1_ff, v2_ff, v3_ff;
   logic en1, en2, en3;
   hpe_lane_type lane1_ff, lane2_ff, lane3_ff;

   logic                     active;
   logic signed [POINT_W-1:0] a_eff;
   logic signed [COEF_W-1:0]  c_eff;

   logic signed [PA_W-1:0] pra_in [NLR];
   logic signed [PA_W-1:0] pra_ff [NLR];
   logic signed [PC_W-1:0] pbc_in [NLB];
   logic signed [PC_W-1:0] pbc_ff [NLB];

   logic signed [RO_W-1:0] ra_in, ra_ff;
   logic signed [RO_W-1:0] term_in, term_ff;
   logic signed [RO_W-1:0] r3_in, r3_ff;

   // Advance a stage when it is empty or the next one moves
   assign en3      = !v3_ff || down_ready;
   assign en2      = !v2_ff || en3;
   assign en1      = !v1_ff || en2;
   assign up_ready = en1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= up_valid;
         if (en2) v2_ff <= v1_ff;
         if (en3) v3_ff <= v2_ff;
      end
   end

   // Steps above the degree in use pass r through as r * 1 + 0
   assign active = (up_lane.degree > DEG_W'(COEF_IDX));
   assign a_eff  = active ? up_lane.point_a : POINT_W'(1);
   assign c_eff  = active ? coef : COEF_W'(0);

   // Limb products: r by a and b^k by the coefficient
   always_comb begin
      for (int k = 0; k < NLR; k++) begin
         if (k == NLR - 1) begin
            pra_in[k] = $signed(r_in[LIMB_W*k +: LIMB_W]) * a_eff;
         end else begin
            pra_in[k] = $signed({1'b0, r_in[LIMB_W*k +: LIMB_W]}) * a_eff;
         end
      end
      for (int k = 0; k < NLB; k++) begin
         pbc_in[k] = $signed({1'b0, bp_in[LIMB_W*k +: LIMB_W]}) * c_eff;
      end
   end

   // Collapse the partial products
   always_comb begin
      ra_in   = '0;
      term_in = '0;
      for (int k = 0; k < NLR; k++) begin
         ra_in = ra_in + (RO_W'(pra_ff[k]) << (LIMB_W * k));
      end
      for (int k = 0; k < NLB; k++) begin
         term_in = term_in + (RO_W'(pbc_ff[k]) << (LIMB_W * k));
      end
   end

   assign r3_in = ra_ff + term_ff;

   // Hold data registers while stalled
   always_ff @(posedge clock) begin
      if (en1) begin
         lane1_ff <= up_lane;
         pra_ff   <= pra_in;
         pbc_ff   <= pbc_in;
      end
      if (en2) begin
         lane2_ff <= lane1_ff;
         ra_ff    <= ra_in;
         term_ff  <= term_in;
      end
      if (en3) begin
         lane3_ff <= lane2_ff;
         r3_ff    <= r3_in;
      end
   end

   assign down_valid = v3_ff;
   assign down_lane  = lane3_ff;
   assign r_out      = ACC_W'(r3_ff);

   // Next power of b for the following step
   if (HAS_NEXT) begin : g_pow
      localparam int BN_W = LIMB_W * (STEP + 2);

      logic [POINT_W-1:0]  b_eff;
      logic [2*LIMB_W-1:0] pbb_in [NLB];
      logic [2*LIMB_W-1:0] pbb_ff [NLB];
      logic [BN_W-1:0]     bn_in, bn_ff, bp3_ff;

      assign b_eff = active ? up_lane.point_b : POINT_W'(1);

      always_comb begin
         for (int k = 0; k < NLB; k++) begin
            pbb_in[k] = bp_in[LIMB_W*k +: LIMB_W] * b_eff;
         end
      end

      always_comb begin
         bn_in = '0;
         for (int k = 0; k < NLB; k++) begin
            bn_in = bn_in + (BN_W'(pbb_ff[k]) << (LIMB_W * k));
         end
      end

      always_ff @(posedge clock) begin
         if (en1) pbb_ff <= pbb_in;
         if (en2) bn_ff  <= bn_in;
         if (en3) bp3_ff <= bn_ff;
      end

      assign bp_out = POW_W'(bp3_ff);
   end else begin : g_last
      assign bp_out = '0;
   end

endmodule

// ----- hdl/homogeneous_poly_eval_unit.sv -----
// Top level: configuration registers, entry stage, Horner step chain and saturation.
//
// Computes the exact homogeneous norm F(a,b) = sum c_i * a^i * b^(d-i) of each point and
// returns it saturated to signed 64 bits, with a flag when saturation happened. One point
// enters per clock while req_stall is low. The pipeline has one entry stage, three stages
// (limb multiply, product sum, add) for each of the MAX_DEGREE Horner steps, and one
// saturation stage. Degrees below MAX_DEGREE run through the same chain, the upper steps
// passing the value unchanged. Stages hold independently, so empty stages fill while a
// result waits. Write the degree and coefficient registers only while no transaction is
// in flight.
module homogeneous_poly_eval_unit #(
   parameter int MAX_DEGREE = 6
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  hpe_pkg::hpe_req_type                  req_payload,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output hpe_pkg::hpe_rsp_type                  rsp_payload,
   input  logic                                  csr_we,
   input  logic [hpe_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [hpe_pkg::CSR_DATA_W-1:0]        csr_wdata
);
   import hpe_pkg::*;

   localparam int ACC_W  = COEF_W + LIMB_W * MAX_DEGREE + GUARD_W;
   localparam int POW_W  = LIMB_W * MAX_DEGREE;
   localparam int CIDX_W = $clog2(MAX_DEGREE + 1);

   logic        [DEG_W-1:0]  degree_ff;
   logic signed [COEF_W-1:0] coef_ff [MAX_DEGREE+1];
   logic        [CSR_INDEX_W-1:0] coef_sel;
   logic        [DEG_W-1:0]  degree_eff;

   logic                     v0_ff, en0;
   hpe_lane_type             lane0_ff, lane0_in;
   logic signed [COEF_W-1:0] r0_ff;

   logic                     valid_bus [MAX_DEGREE+1];
   logic                     ready_bus [MAX_DEGREE+1];
   hpe_lane_type             lane_bus  [MAX_DEGREE+1];
   logic signed [ACC_W-1:0]  r_bus     [MAX_DEGREE+1];
   logic        [POW_W-1:0]  bp_bus    [MAX_DEGREE+1];

   logic                        vout_ff, en_out;
   hpe_rsp_type                 rsp_ff, rsp_in;
   logic signed [ACC_W-1:0]     acc;
   logic [ACC_W-NORM_W:0]       acc_upper;
   logic                        fits;

   // Configuration registers
   assign coef_sel = csr_index - CSR_COEF_0;

   always_ff @(posedge clock) begin
      if (reset) begin
         degree_ff <= DEG_RESET;
         for (int j = 0; j <= MAX_DEGREE; j++) coef_ff[j] <= '0;
      end else if (csr_we) begin
         if (csr_index == CSR_POLY_DEGREE) begin
            degree_ff <= csr_wdata[DEG_W-1:0];
         end else if (coef_sel <= CSR_INDEX_W'(MAX_DEGREE)) begin
            coef_ff[coef_sel[CIDX_W-1:0]] <= csr_wdata[COEF_W-1:0];
         end
      end
   end

   // Clamp the degree to what the chain supports
   assign degree_eff = (degree_ff > DEG_W'(MAX_DEGREE)) ? DEG_W'(MAX_DEGREE) : degree_ff;

   // Entry stage: capture the point and seed r with the leading coefficient
   assign en0       = !v0_ff || ready_bus[0];
   assign req_stall = !en0;

   always_comb begin
      lane0_in.degree  = degree_eff;
      lane0_in.point_a = req_payload.point_a;
      lane0_in.point_b = req_payload.point_b;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else if (en0) begin
         v0_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en0) begin
         lane0_ff <= lane0_in;
         r0_ff    <= coef_ff[degree_eff[CIDX_W-1:0]];
      end
   end

   assign valid_bus[0] = v0_ff;
   assign lane_bus[0]  = lane0_ff;
   assign r_bus[0]     = ACC_W'(r0_ff);
   assign bp_bus[0]    = POW_W'(lane0_ff.point_b);

   // Horner step chain, highest coefficient first
   for (genvar s = 0; s < MAX_DEGREE; s++) begin : g_step
      hpe_horner_step #(
         .MAX_DEGREE (MAX_DEGREE),
         .STEP       (s)
      ) u_step (
         .clock      (clock),
         .reset      (reset),
         .up_valid   (valid_bus[s]),
         .up_ready   (ready_bus[s]),
         .up_lane    (lane_bus[s]),
         .r_in       (r_bus[s]),
         .bp_in      (bp_bus[s]),
         .coef       (coef_ff[MAX_DEGREE-1-s]),
         .down_valid (valid_bus[s+1]),
         .down_ready (ready_bus[s+1]),
         .down_lane  (lane_bus[s+1]),
         .r_out      (r_bus[s+1]),
         .bp_out     (bp_bus[s+1])
      );
   end

   // Output stage: saturate to 64 bits
   assign en_out               = !vout_ff || !rsp_stall;
   assign ready_bus[MAX_DEGREE] = en_out;

   assign acc       = r_bus[MAX_DEGREE];
   assign acc_upper = acc[ACC_W-1:NORM_W-1];
   assign fits      = (&acc_upper) || !(|acc_upper);

   always_comb begin
      if (fits) begin
         rsp_in.norm_value = acc[NORM_W-1:0];
         rsp_in.saturated  = 1'b0;
      end else begin
         rsp_in.norm_value = acc[ACC_W-1] ? NORM_MIN : NORM_MAX;
         rsp_in.saturated  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vout_ff <= 1'b0;
      end else if (en_out) begin
         vout_ff <= valid_bus[MAX_DEGREE];
      end
   end

   always_ff @(posedge clock) begin
      if (en_out) rsp_ff <= rsp_in;
   end

   assign rsp_valid   = vout_ff;
   assign rsp_payload = rsp_ff;

endmodule
